### rtl/spq_pkg.sv
// Shared constants, request and status codes, and control types of the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] REQ_PREPEND = 2'd0;
  localparam logic [1:0] REQ_INSERT  = 2'd1;
  localparam logic [1:0] REQ_REMOVE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  // controller to datapath
  typedef struct packed {
    logic load_req;  // capture the accepted request
    logic exec;      // apply request to the queue and load the result register
  } cmd_t;

endpackage
`default_nettype wire

### rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller plus cell datapath.
// A request is captured at its transfer edge; once the result register is free, all cells
//   compare against the key and shift in parallel and the result register is loaded.
// A request is taken only after the previous one has executed, even while its result
//   waits in the output register; execution waits while that register is occupied.
// Reset clears the controller and the entry count; entry cells are not reset.
`default_nettype none
module sorted_priority_queue_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [1:0]                        req_type_i,
  input  wire  signed [spq_pkg::KEY_W-1:0]  in_key_i,
  input  wire  [spq_pkg::PAY_W-1:0]         in_payload_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [spq_pkg::KEY_W-1:0]  out_key_o,
  output logic [spq_pkg::PAY_W-1:0]         out_payload_o,
  output logic [spq_pkg::CNT_W-1:0]         occupancy_o
);
  import spq_pkg::*;

  cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  spq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .in_key_i      (in_key_i),
    .in_payload_i  (in_payload_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .occupancy_o   (occupancy_o)
  );

endmodule
`default_nettype wire

### rtl/spq_ctrl.sv
// Sequencing controller: input/output handshakes and datapath commands.
`default_nettype none
module spq_ctrl (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output spq_pkg::cmd_t cmd_o
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free       = !out_valid_q || out_ready_i;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.load_req = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.exec     = (state_q == S_EXEC) && out_free;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait here until the result register can take the new result
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while previous one still executing");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("executed request produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before transfer");

endmodule
`default_nettype wire

### rtl/spq_dp.sv
// Datapath: sorted entry cells with parallel compare and shift, fill count, result register.
`default_nettype none
module spq_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  spq_pkg::cmd_t                     cmd_i,
  input  wire  [1:0]                        req_type_i,
  input  wire  signed [spq_pkg::KEY_W-1:0]  in_key_i,
  input  wire  [spq_pkg::PAY_W-1:0]         in_payload_i,
  output logic [1:0]                        status_o,
  output logic signed [spq_pkg::KEY_W-1:0]  out_key_o,
  output logic [spq_pkg::PAY_W-1:0]         out_payload_o,
  output logic [spq_pkg::CNT_W-1:0]         occupancy_o
);
  import spq_pkg::*;

  // captured request
  logic [1:0]       req_q;
  logic [KEY_W-1:0] req_key_q;
  logic [PAY_W-1:0] req_pay_q;

  // entry cells, head at index 0
  logic [KEY_W-1:0] key_q [DEPTH];
  logic [KEY_W-1:0] key_d [DEPTH];
  logic [PAY_W-1:0] pay_q [DEPTH];
  logic [PAY_W-1:0] pay_d [DEPTH];
  logic [CNT_W-1:0] count_q, count_d;

  // result register
  logic [1:0]       status_q;
  logic [KEY_W-1:0] okey_q;
  logic [PAY_W-1:0] opay_q;
  logic [CNT_W-1:0] occ_q;

  logic             full, empty, is_add, do_ins, do_rem;
  logic [KEY_W-1:0] new_key;
  logic [DEPTH-1:0] hit;
  logic [1:0]       status_d;

  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign is_add = (req_q == REQ_PREPEND) || (req_q == REQ_INSERT);
  assign do_ins = cmd_i.exec && is_add && !full;
  assign do_rem = cmd_i.exec && (req_q == REQ_REMOVE) && !empty;

  always_comb begin
    if (req_q == REQ_INSERT) begin
      new_key = req_key_q;
    end else if (empty) begin
      new_key = '0;
    end else if (key_q[0] == KEY_MIN) begin
      new_key = KEY_MIN;
    end else begin
      new_key = key_q[0] - KEY_W'(1);
    end
  end

  // hit marks cells at or after the insert point; monotone since cells are sorted
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign hit[g] = (req_q != REQ_INSERT) || (CNT_W'(g) >= count_q) ||
                    !($signed(key_q[g]) < $signed(req_key_q));

    if (g == 0) begin : g_head
      always_comb begin
        key_d[g] = key_q[g];
        pay_d[g] = pay_q[g];
        if (do_ins) begin
          if (hit[g]) begin
            key_d[g] = new_key;
            pay_d[g] = req_pay_q;
          end
        end else if (do_rem) begin
          key_d[g] = key_q[g+1];
          pay_d[g] = pay_q[g+1];
        end
      end
    end else if (g == DEPTH - 1) begin : g_tail
      always_comb begin
        key_d[g] = key_q[g];
        pay_d[g] = pay_q[g];
        if (do_ins) begin
          if (hit[g-1]) begin
            key_d[g] = key_q[g-1];
            pay_d[g] = pay_q[g-1];
          end else if (hit[g]) begin
            key_d[g] = new_key;
            pay_d[g] = req_pay_q;
          end
        end
      end
    end else begin : g_mid
      always_comb begin
        key_d[g] = key_q[g];
        pay_d[g] = pay_q[g];
        if (do_ins) begin
          if (hit[g-1]) begin
            key_d[g] = key_q[g-1];
            pay_d[g] = pay_q[g-1];
          end else if (hit[g]) begin
            key_d[g] = new_key;
            pay_d[g] = req_pay_q;
          end
        end else if (do_rem) begin
          key_d[g] = key_q[g+1];
          pay_d[g] = pay_q[g+1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      key_q[g] <= key_d[g];
      pay_q[g] <= pay_d[g];
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    case (req_q)
      REQ_PREPEND, REQ_INSERT: status_d = full ? ST_FULL : ST_OK;
      REQ_REMOVE:              status_d = empty ? ST_EMPTY : ST_OK;
      default:                 status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q     <= req_type_i;
      req_key_q <= in_key_i;
      req_pay_q <= in_payload_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      okey_q   <= do_rem ? key_q[0] : '0;
      opay_q   <= do_rem ? pay_q[0] : '0;
      occ_q    <= count_d;
    end
  end

  assign status_o      = status_q;
  assign out_key_o     = okey_q;
  assign out_payload_o = opay_q;
  assign occupancy_o   = occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_add && full) |=> (count_q == CNT_W'(DEPTH)))
    else $error("rejected insert changed the count");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rem |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("remove did not decrement the count");

endmodule
`default_nettype wire
